@@ hw/rtl/nts_pkg.sv @@
// Package for the note token stream parser: phase codes, the result record,
// character codes and the fixed note name and frequency table.
// No dependencies; the top level, parser, formatter, queue and bench import it.
package nts_pkg;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_NAME,
    PH_DIGITS,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [6:0]  note_index;
    logic [9:0]  frequency;
    logic [15:0] duration_ms;
    logic [39:0] name_chars;
    logic [2:0]  name_length;
    logic        run_last;
  } note_t;

  localparam int NAME_OUT   = 5;
  localparam int TABLE_SIZE = 28;
  localparam int FIFO_DEPTH = 4;

  localparam logic [15:0] DFLT_DUR_RST = 16'd200;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Note names, first character in the low byte.
  localparam logic [23:0] NOTE_NAME [TABLE_SIZE] = '{
    {8'h00, "3", "C"}, {"3", "#", "C"}, {8'h00, "3", "D"}, {"3", "#", "D"},
    {8'h00, "3", "E"}, {8'h00, "3", "F"}, {"3", "#", "F"}, {8'h00, "3", "G"},
    {"3", "#", "G"}, {8'h00, "3", "A"}, {"3", "#", "A"}, {8'h00, "3", "B"},
    {8'h00, "4", "C"}, {"4", "#", "C"}, {8'h00, "4", "D"}, {"4", "#", "D"},
    {8'h00, "4", "E"}, {8'h00, "4", "F"}, {"4", "#", "F"}, {8'h00, "4", "G"},
    {"4", "#", "G"}, {8'h00, "4", "A"}, {"4", "#", "A"}, {8'h00, "4", "B"},
    {8'h00, "5", "C"}, {8'h00, "5", "D"}, {8'h00, "5", "E"}, {8'h00, "5", "G"}
  };

  localparam logic [1:0] NOTE_LEN [TABLE_SIZE] = '{
    2'd2, 2'd3, 2'd2, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd2, 2'd3, 2'd2,
    2'd2, 2'd3, 2'd2, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd2, 2'd3, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd2
  };

  localparam logic [9:0] NOTE_FREQ [TABLE_SIZE] = '{
    10'd131, 10'd139, 10'd147, 10'd156, 10'd165, 10'd175, 10'd185, 10'd196,
    10'd208, 10'd220, 10'd233, 10'd247, 10'd262, 10'd277, 10'd294, 10'd311,
    10'd330, 10'd349, 10'd370, 10'd392, 10'd415, 10'd440, 10'd466, 10'd494,
    10'd523, 10'd587, 10'd659, 10'd784
  };

endpackage

@@ hw/rtl/nts_ifs.sv @@
// Valid/ready channel interfaces for the note token stream parser:
// the text byte input channel and the note result channel. No dependencies.
interface nts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nts_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  note_index;
  logic [9:0]  frequency;
  logic [15:0] duration_ms;
  logic [39:0] name_chars;
  logic [2:0]  name_length;
  logic        run_last;

  modport source (output valid, output note_index, output frequency, output duration_ms,
                  output name_chars, output name_length, output run_last, input ready);
  modport sink (input valid, input note_index, input frequency, input duration_ms,
                input name_chars, input name_length, input run_last, output ready);
endinterface

@@ hw/rtl/note_token_stream_parser.sv @@
// Note token stream parser: song text bytes in, notes out.
// Accepted bytes are held in the input register, then their notes go to the result
// queue. Throughput: one byte per cycle while the queue has room for two notes; a byte
// closing two tokens delivers two notes, one at a time, from the four-entry queue.
// Reset (rst_n low, synchronous): parser back to whitespace skipping, note count zero, queue
// empty, default duration 200. Depends on nts_pkg, nts_ifs, nts_parser, nts_note_fmt, nts_out_fifo.
module note_token_stream_parser #(
  parameter int MAX_NOTES  = 128,
  parameter int NAME_STORE = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  nts_in_if.sink      in_if,
  nts_out_if.source   out_if
);
  import nts_pkg::*;

  localparam int CNT_W = $clog2(NAME_STORE + 1);

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic [15:0] dflt_r;
  logic        room;
  logic        step;

  logic [1:0]              tok_valid;
  logic [NAME_STORE*8-1:0] tok_name  [2];
  logic [CNT_W-1:0]        tok_cnt   [2];
  logic [31:0]             tok_acc   [2];
  logic [6:0]              tok_index [2];
  note_t                   fmt_note  [2];
  note_t                   push_note [2];
  note_t                   head_note;
  logic                    head_valid;

  assign step        = in_v_r && room;
  assign in_if.ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      dflt_r <= DFLT_DUR_RST;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_v_r <= 1'b1;
      end else if (step) begin
        in_v_r <= 1'b0;
      end
      if (cfg_we) dflt_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.data_byte;
      in_last_r <= in_if.last_byte;
    end
  end

  nts_parser #(.MAX_NOTES(MAX_NOTES), .NAME_STORE(NAME_STORE)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .tok_valid (tok_valid),
    .tok_name  (tok_name),
    .tok_cnt   (tok_cnt),
    .tok_acc   (tok_acc),
    .tok_index (tok_index)
  );

  for (genvar s = 0; s < 2; s++) begin : g_fmt
    nts_note_fmt #(.NAME_STORE(NAME_STORE)) u_fmt (
      .tok_name  (tok_name[s]),
      .tok_cnt   (tok_cnt[s]),
      .tok_acc   (tok_acc[s]),
      .tok_index (tok_index[s]),
      .dflt_dur  (dflt_r),
      .note      (fmt_note[s])
    );
  end

  // The final note of a last byte carries the run end flag.
  always_comb begin
    push_note[0] = fmt_note[0];
    push_note[1] = fmt_note[1];
    push_note[0].run_last = in_last_r && !tok_valid[1];
    push_note[1].run_last = in_last_r;
  end

  nts_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step ? tok_valid : 2'b00),
    .push_note  (push_note),
    .pop        (out_if.valid && out_if.ready),
    .room       (room),
    .head_valid (head_valid),
    .head_note  (head_note)
  );

  assign out_if.valid       = head_valid;
  assign out_if.note_index  = head_note.note_index;
  assign out_if.frequency   = head_note.frequency;
  assign out_if.duration_ms = head_note.duration_ms;
  assign out_if.name_chars  = head_note.name_chars;
  assign out_if.name_length = head_note.name_length;
  assign out_if.run_last    = head_note.run_last;

endmodule

@@ hw/rtl/nts_parser.sv @@
// Parse state machine of the note token stream parser: consumes one byte per
// step and hands out up to two completed tokens. Depends on nts_pkg.
module nts_parser #(
  parameter int MAX_NOTES  = 128,
  parameter int NAME_STORE = 6,
  parameter int CNT_W      = $clog2(NAME_STORE + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output logic [1:0]              tok_valid,
  output logic [NAME_STORE*8-1:0] tok_name [2],
  output logic [CNT_W-1:0]        tok_cnt  [2],
  output logic [31:0]             tok_acc  [2],
  output logic [6:0]              tok_index [2]
);
  import nts_pkg::*;

  localparam int NE_W = $clog2(MAX_NOTES + 1);

  phase_t                  phase_r, phase_nxt;
  logic [NAME_STORE*8-1:0] name_r, name_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [31:0]             acc_r, acc_nxt;
  logic [NE_W-1:0]         ne_r, ne_nxt;

  logic is_ws, is_sep, is_digit, is_colon;

  assign is_colon = (data_byte == CH_COLON);
  assign is_sep   = (data_byte == CH_SPACE) || (data_byte == CH_LF);
  assign is_ws    = is_sep || (data_byte == CH_CR);
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

  // Next state. A completed token is captured, counted and cleared; the
  // byte that closed it may then open the next token. A last byte flushes.
  always_comb begin
    logic do_emit;
    logic do_start;
    logic slot;
    phase_nxt = phase_r;
    name_nxt  = name_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    ne_nxt    = ne_r;
    tok_valid = 2'b00;
    do_emit   = 1'b0;
    do_start  = 1'b0;
    slot      = 1'b0;
    for (int s = 0; s < 2; s++) begin
      tok_name[s]  = name_r;
      tok_cnt[s]   = cnt_r;
      tok_acc[s]   = acc_r;
      tok_index[s] = 7'(ne_r);
    end

    unique case (phase_r)
      PH_SKIP: begin
        do_start = 1'b1;
      end
      PH_NAME: begin
        if (is_colon) begin
          phase_nxt = PH_DIGITS;
          acc_nxt   = '0;
        end else if (is_sep || (cnt_r >= CNT_W'(NAME_STORE))) begin
          do_emit  = 1'b1;
          do_start = 1'b1;
        end else begin
          for (int k = 0; k < NAME_STORE; k++) begin
            if (CNT_W'(k) == cnt_r) name_nxt[8*k +: 8] = data_byte;
          end
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          acc_nxt = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0}
                    + {28'd0, data_byte[3:0]};
        end else begin
          do_emit  = 1'b1;
          do_start = 1'b1;
        end
      end
      PH_HALT: begin
        do_start = 1'b0;
      end
      default: begin
        do_start = 1'b0;
      end
    endcase

    if (do_emit) begin
      tok_valid[0] = 1'b1;
      ne_nxt    = ne_nxt + NE_W'(1);
      name_nxt  = '0;
      cnt_nxt   = '0;
      acc_nxt   = '0;
      phase_nxt = (ne_nxt >= NE_W'(MAX_NOTES)) ? PH_HALT : PH_SKIP;
      slot      = 1'b1;
    end

    if (do_start && (phase_nxt == PH_SKIP) && !is_ws) begin
      name_nxt = '0;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      if (is_colon) begin
        phase_nxt = PH_DIGITS;
      end else begin
        name_nxt[7:0] = data_byte;
        cnt_nxt       = CNT_W'(1);
        phase_nxt     = PH_NAME;
      end
    end

    if (last_byte) begin
      if ((phase_nxt == PH_NAME) || (phase_nxt == PH_DIGITS)) begin
        tok_valid[slot] = 1'b1;
        tok_name[slot]  = name_nxt;
        tok_cnt[slot]   = cnt_nxt;
        tok_acc[slot]   = acc_nxt;
        tok_index[slot] = 7'(ne_nxt);
      end
      phase_nxt = PH_SKIP;
      name_nxt  = '0;
      cnt_nxt   = '0;
      acc_nxt   = '0;
      ne_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      name_r  <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
      ne_r    <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      name_r  <= name_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      ne_r    <= ne_nxt;
    end
  end

endmodule

@@ hw/rtl/nts_note_fmt.sv @@
// Result formatter of the note token stream parser: table lookup, duration
// choice and name byte packing for one completed token. Depends on nts_pkg.
module nts_note_fmt #(
  parameter int NAME_STORE = 6,
  parameter int CNT_W      = $clog2(NAME_STORE + 1)
) (
  input  logic [NAME_STORE*8-1:0] tok_name,
  input  logic [CNT_W-1:0]        tok_cnt,
  input  logic [31:0]             tok_acc,
  input  logic [6:0]              tok_index,
  input  logic [15:0]             dflt_dur,
  output nts_pkg::note_t          note
);
  import nts_pkg::*;

  localparam int OUT_MAX = (NAME_STORE - 1 < NAME_OUT) ? NAME_STORE - 1 : NAME_OUT;

  logic [8*(NAME_STORE+NAME_OUT)-1:0] pad;
  logic [CNT_W-1:0]                   len;
  logic [2:0]                         olen;
  logic [9:0]                         freq;
  logic [39:0]                        chars;

  assign pad = {{(8*NAME_OUT){1'b0}}, tok_name};

  // The name ends at the first zero byte.
  always_comb begin
    logic stop;
    len  = '0;
    stop = 1'b0;
    for (int k = 0; k < NAME_STORE; k++) begin
      if (!stop && (CNT_W'(k) < tok_cnt) && (pad[8*k +: 8] != 8'h00)) begin
        len = CNT_W'(k + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  assign olen = (32'(len) > OUT_MAX) ? 3'(OUT_MAX) : 3'(len);

  always_comb begin
    chars = '0;
    for (int k = 0; k < NAME_OUT; k++) begin
      if (3'(k) < olen) chars[8*k +: 8] = pad[8*k +: 8];
    end
  end

  always_comb begin
    logic hit;
    logic found;
    freq  = '0;
    found = 1'b0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      hit = (len == CNT_W'(NOTE_LEN[i]));
      for (int k = 0; k < 3; k++) begin
        if ((2'(k) < NOTE_LEN[i]) && (pad[8*k +: 8] != NOTE_NAME[i][8*k +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit && !found) begin
        freq  = NOTE_FREQ[i];
        found = 1'b1;
      end
    end
  end

  always_comb begin
    note             = '0;
    note.note_index  = tok_index;
    note.frequency   = freq;
    note.duration_ms = (tok_acc != 32'd0) ? tok_acc[15:0] : dflt_dur;
    note.name_chars  = chars;
    note.name_length = olen;
    note.run_last    = 1'b0;
  end

endmodule

@@ hw/rtl/nts_out_fifo.sv @@
// Result queue of the note token stream parser: takes up to two notes per
// cycle and delivers one per cycle while it is popped. Depends on nts_pkg.
module nts_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     push,
  input  nts_pkg::note_t push_note [2],
  input  logic           pop,
  output logic           room,
  output logic           head_valid,
  output nts_pkg::note_t head_note
);
  import nts_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  note_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_push;

  assign n_push     = CNT_W'(push[0]) + CNT_W'(push[1]);
  assign room       = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head_note  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push[0]) mem[wr_ptr_r] <= push_note[0];
    if (push[1]) mem[wr_ptr_r + PTR_W'(1)] <= push_note[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      count_r <= count_r + n_push - CNT_W'(pop);
    end
  end

endmodule

@@ hw/rtl/nts_checker.sv @@
// Port level checks for the note token stream parser, attached to the top
// level by the bind below. Depends on the top level's ports only.
module nts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  out_note_index,
  input logic [9:0]  out_frequency,
  input logic [15:0] out_duration_ms,
  input logic [2:0]  out_name_length
);

  // The result queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled item keeps its note index, frequency and duration.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_note_index)
      && $stable(out_frequency) && $stable(out_duration_ms))
    else $error("stalled item changed");

  // Every table note name is two or three bytes long.
  a_freq_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frequency != 10'd0) |->
      (out_name_length == 3'd2) || (out_name_length == 3'd3))
    else $error("frequency without a matching name length");

  a_name_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_name_length <= 3'd5) && (out_frequency <= 10'd784))
    else $error("name length or frequency out of range");

endmodule

bind note_token_stream_parser nts_checker u_nts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_note_index  (out_if.note_index),
  .out_frequency   (out_if.frequency),
  .out_duration_ms (out_if.duration_ms),
  .out_name_length (out_if.name_length)
);

@@ verif/tb_top.sv @@
// Self-checking bench for the note token stream parser: song text in, notes out.
// Holds its own parser model in a small class and drives both channels at random.
// Depends on nts_pkg, nts_ifs and note_token_stream_parser.
`timescale 1ns / 100ps

module tb_top;
  import nts_pkg::*;

  localparam int NOTE_CAP  = 128;
  localparam int NAME_CAP  = 6;
  localparam int ITEM_GOAL = 1800;
  localparam int STALL_CAP = 1000;

  class song_parse_model;
    localparam int NAME_CAP_M = 6;
    localparam int NOTE_CAP_M = 128;

    phase_t      phase;
    logic [7:0]  nbuf [NAME_CAP_M];
    int          ncount;
    logic [31:0] acc;
    int          emitted;
    logic [15:0] dflt;
    note_t       due_notes [$];
    int          errors;
    int          notes_checked;
    int          halts;
    string       tone_name [TABLE_SIZE];
    int          tone_hz [TABLE_SIZE];

    function new();
      tone_name = '{"C3", "C#3", "D3", "D#3", "E3", "F3", "F#3", "G3", "G#3", "A3",
                    "A#3", "B3", "C4", "C#4", "D4", "D#4", "E4", "F4", "F#4", "G4",
                    "G#4", "A4", "A#4", "B4", "C5", "D5", "E5", "G5"};
      tone_hz = '{131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247,
                  262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
                  523, 587, 659, 784};
      dflt = 16'd200;
      phase = PH_SKIP;
      emitted = 0;
      errors = 0;
      notes_checked = 0;
      halts = 0;
      clear_token();
    endfunction

    function void set_default(logic [15:0] v);
      dflt = v;
    endfunction

    function int pending();
      return due_notes.size();
    endfunction

    function void clear_token();
      for (int k = 0; k < NAME_CAP_M; k++) nbuf[k] = 8'h00;
      ncount = 0;
      acc = 32'd0;
    endfunction

    function int tone_of(int len);
      string s;
      bit same;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        s = tone_name[i];
        if (s.len() != len) continue;
        same = 1'b1;
        for (int k = 0; k < len; k++) begin
          if (s[k] != nbuf[k]) same = 1'b0;
        end
        if (same) return tone_hz[i];
      end
      return 0;
    endfunction

    function void close_token();
      note_t n;
      int len;
      int olen;
      logic [39:0] chars;
      len = 0;
      chars = '0;
      while (len < ncount && len < NAME_CAP_M && nbuf[len] != 8'h00) len++;
      olen = (len > NAME_OUT) ? NAME_OUT : len;
      for (int k = 0; k < olen; k++) chars |= 40'(nbuf[k]) << (8 * k);
      n.note_index  = 7'(emitted);
      n.frequency   = 10'(tone_of(len));
      n.duration_ms = (acc != 32'd0) ? acc[15:0] : dflt;
      n.name_chars  = chars;
      n.name_length = 3'(olen);
      n.run_last    = 1'b0;
      due_notes.push_back(n);
      emitted++;
      clear_token();
      if (emitted >= NOTE_CAP_M) begin
        phase = PH_HALT;
        halts++;
      end else begin
        phase = PH_SKIP;
      end
    endfunction

    function void open_token(logic [7:0] b);
      if (phase != PH_SKIP) return;
      if (b == CH_SPACE || b == CH_LF || b == CH_CR) return;
      clear_token();
      if (b == CH_COLON) begin
        phase = PH_DIGITS;
      end else begin
        nbuf[0] = b;
        ncount = 1;
        phase = PH_NAME;
      end
    endfunction

    // Called once per accepted text byte.
    function void take_byte(logic [7:0] b, logic lst);
      int before_cnt;
      note_t tail;
      before_cnt = due_notes.size();
      case (phase)
        PH_SKIP: open_token(b);
        PH_NAME: begin
          if (b == CH_COLON) begin
            phase = PH_DIGITS;
            acc = 32'd0;
          end else if (b == CH_SPACE || b == CH_LF || ncount >= NAME_CAP_M) begin
            close_token();
            open_token(b);
          end else begin
            nbuf[ncount] = b;
            ncount++;
          end
        end
        PH_DIGITS: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            acc = acc * 32'd10 + 32'(b - CH_ZERO);
          end else begin
            close_token();
            open_token(b);
          end
        end
        default: ;
      endcase
      if (lst) begin
        if (phase == PH_NAME || phase == PH_DIGITS) close_token();
        // Only a note caused by this byte may carry the end-of-song flag.
        if (due_notes.size() > before_cnt) begin
          tail = due_notes.pop_back();
          tail.run_last = 1'b1;
          due_notes.push_back(tail);
        end
        phase = PH_SKIP;
        clear_token();
        emitted = 0;
      end
    endfunction

    function void field_check(string field, logic [39:0] e, logic [39:0] a);
      if (a !== e) begin
        errors++;
        if (errors <= 200)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
      end
    endfunction

    function void match_note(note_t got);
      note_t e;
      if (due_notes.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: unexpected note, expected none, actual %0h", $time, got);
        return;
      end
      e = due_notes.pop_front();
      notes_checked++;
      field_check("note_index", 40'(e.note_index), 40'(got.note_index));
      field_check("frequency", 40'(e.frequency), 40'(got.frequency));
      field_check("duration_ms", 40'(e.duration_ms), 40'(got.duration_ms));
      field_check("name_chars", e.name_chars, got.name_chars);
      field_check("name_length", 40'(e.name_length), 40'(got.name_length));
      field_check("run_last", 40'(e.run_last), 40'(got.run_last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  nts_in_if  in_ch ();
  nts_out_if out_ch ();

  note_token_stream_parser #(
    .MAX_NOTES  (NOTE_CAP),
    .NAME_STORE (NAME_CAP)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  song_parse_model model = new();

  logic [7:0] song_text [$];
  bit         tx_idle;
  bit         rx_idle;
  int         rx_hold;
  int         idle_cycles;
  int         bytes_sent;
  int         songs;
  int         cfg_writes;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly short pauses, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      rx_hold <= gap_len() - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Accepted items feed the model; the watchdog ends a hung run.
  always @(posedge clk) begin
    note_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) model.take_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.note_index  = out_ch.note_index;
        got.frequency   = out_ch.frequency;
        got.duration_ms = out_ch.duration_ms;
        got.name_chars  = out_ch.name_chars;
        got.name_length = out_ch.name_length;
        got.run_last    = out_ch.run_last;
        model.match_note(got);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_CAP) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_song();
    for (int i = 0; i < song_text.size(); i++) send_byte(song_text[i], i == song_text.size() - 1);
    song_text.delete();
    songs++;
  endtask

  // Hold the sender until every note is out and the pipeline has settled.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_default(v);
    cfg_writes++;
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] name_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 8'($urandom_range(0, 255));
    if (r < 3) return CH_CR;
    if (r < 5) return "#";
    if (r < 8) return CH_ZERO + 8'($urandom_range(0, 9));
    return "A" + 8'($urandom_range(0, 25));
  endfunction

  function automatic void add_digits(int nd);
    song_text.push_back(CH_COLON);
    repeat (nd) song_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void add_token();
    int pick;
    string nm;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) song_text.push_back(blank_byte());
    if (pick < 10) begin
      repeat ($urandom_range(1, 8)) song_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 70) begin
      nm = model.tone_name[$urandom_range(0, TABLE_SIZE - 1)];
      for (int k = 0; k < nm.len(); k++) song_text.push_back(nm[k]);
    end else if (pick < 78) begin
      nm = "REST";
      for (int k = 0; k < nm.len(); k++) song_text.push_back(nm[k]);
    end else begin
      repeat ($urandom_range(0, 8)) song_text.push_back(name_byte());
    end
    if ($urandom_range(0, 4) != 0)
      add_digits(($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5));
    song_text.push_back(blank_byte());
  endfunction

  initial begin
    string lead;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    rx_hold = 0;
    idle_cycles = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    bytes_sent = 0;
    songs = 0;
    cfg_writes = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Leading blank, a wrapped duration, a full name with a carriage return and a zero
    // byte, a non-digit after digits, an empty name and a final byte closing two notes.
    lead = " G5:65536XY";
    for (int k = 0; k < lead.len(); k++) song_text.push_back(lead[k]);
    song_text.push_back(CH_CR);
    song_text.push_back(8'h00);
    song_text.push_back("Z");
    song_text.push_back(8'hFF);
    lead = "WQ::4Z";
    for (int k = 0; k < lead.len(); k++) song_text.push_back(lead[k]);
    send_song();
    quiesce();

    while (bytes_sent < ITEM_GOAL) begin
      if (songs % 5 == 1) begin
        quiesce();
        case (cfg_writes % 4)
          0:       write_default(16'h0000);
          1:       write_default(16'hFFFF);
          default: write_default(16'($urandom_range(0, 65535)));
        endcase
      end
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (songs == 4 || songs == 27) begin
        // Long enough to run into the note limit; the tail is ignored.
        repeat (NOTE_CAP + 4) begin
          lead = model.tone_name[$urandom_range(0, TABLE_SIZE - 1)];
          for (int k = 0; k < lead.len(); k++) song_text.push_back(lead[k]);
          if ($urandom_range(0, 3) == 0) add_digits($urandom_range(1, 4));
          song_text.push_back(blank_byte());
        end
      end else begin
        repeat ($urandom_range(1, 10)) add_token();
        case ($urandom_range(0, 3))
          0: repeat ($urandom_range(1, 3)) if (song_text.size() > 1) void'(song_text.pop_back());
          1: begin
            void'(song_text.pop_back());
            song_text.push_back("A" + 8'($urandom_range(0, 25)));
          end
          default: ;
        endcase
      end
      send_song();
    end
    quiesce();
    repeat (8) @(posedge clk);

    $display("Run: %0d text bytes in %0d songs, %0d notes checked.",
             bytes_sent, songs, model.notes_checked);
    $display("Default duration written %0d times; note limit reached %0d times.",
             cfg_writes, model.halts);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/nts_pkg.sv
hw/rtl/nts_ifs.sv
hw/rtl/nts_parser.sv
hw/rtl/nts_note_fmt.sv
hw/rtl/nts_out_fifo.sv
hw/rtl/note_token_stream_parser.sv
hw/rtl/nts_checker.sv
verif/tb_top.sv
